FILE: hdl/hrhp_pkg.sv
`timescale 1ns / 1ps

package hrhp_pkg;

    // Parser phases.
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_URI     = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_NAME    = 4'd3;
    localparam logic [3:0] PH_CTYPE   = 4'd4;
    localparam logic [3:0] PH_CSEEK   = 4'd5;
    localparam logic [3:0] PH_CHARSET = 4'd6;
    localparam logic [3:0] PH_LENGTH  = 4'd7;
    localparam logic [3:0] PH_OTHER   = 4'd8;
    localparam logic [3:0] PH_BODY    = 4'd9;
    localparam logic [3:0] PH_IGNORE  = 4'd10;

    // Byte classes.
    localparam logic [3:0] CLS_METHOD  = 4'd0;
    localparam logic [3:0] CLS_URI     = 4'd1;
    localparam logic [3:0] CLS_VERSION = 4'd2;
    localparam logic [3:0] CLS_DELIM   = 4'd3;
    localparam logic [3:0] CLS_NAME    = 4'd4;
    localparam logic [3:0] CLS_CTYPE   = 4'd5;
    localparam logic [3:0] CLS_CHARSET = 4'd6;
    localparam logic [3:0] CLS_LENGTH  = 4'd7;
    localparam logic [3:0] CLS_VALUE   = 4'd8;
    localparam logic [3:0] CLS_BODY    = 4'd9;
    localparam logic [3:0] CLS_IGNORED = 4'd10;

    // Method codes.
    localparam logic [2:0] METH_UNKNOWN = 3'd0;

    // Header name match results.
    localparam logic [1:0] HDR_NONE  = 2'd0;
    localparam logic [1:0] HDR_CTYPE = 2'd1;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";

    localparam int NUM_METHODS = 4;
    localparam int NUM_NAMES   = 3;

    localparam logic [3:0] POS_MAX = 4'd15;

    localparam logic [7:0] METHOD_CHARS [NUM_METHODS][16] = '{
        '{0: "H", 1: "E", 2: "A", 3: "D", default: 8'h00},
        '{0: "G", 1: "E", 2: "T", default: 8'h00},
        '{0: "P", 1: "O", 2: "S", 3: "T", default: 8'h00},
        '{0: "O", 1: "P", 2: "T", 3: "I", 4: "O", 5: "N", 6: "S", default: 8'h00}
    };
    localparam logic [3:0] METHOD_LENS [NUM_METHODS] = '{4'd4, 4'd3, 4'd4, 4'd7};

    localparam logic [7:0] NAME_CHARS [NUM_NAMES][16] = '{
        '{0: "C", 1: "o", 2: "n", 3: "t", 4: "e", 5: "n", 6: "t", 7: "-",
          8: "T", 9: "y", 10: "p", 11: "e", default: 8'h00},
        '{0: "c", 1: "o", 2: "n", 3: "t", 4: "e", 5: "n", 6: "t", 7: "-",
          8: "l", 9: "e", 10: "n", 11: "g", 12: "t", 13: "h", default: 8'h00},
        '{0: "C", 1: "o", 2: "n", 3: "t", 4: "e", 5: "n", 6: "t", 7: "-",
          8: "L", 9: "e", 10: "n", 11: "g", 12: "t", 13: "h", default: 8'h00}
    };
    localparam logic [3:0] NAME_LENS [NUM_NAMES] = '{4'd12, 4'd14, 4'd14};

    // What the parser hands to the result register for one word.
    typedef struct packed {
        logic [3:0]  byte_class;
        logic [2:0]  method_code;
        logic [31:0] content_length;
        logic        length_present;
        logic        headers_done;
    } hrhp_result_t;

endpackage

FILE: hdl/hrhp_len_acc.sv
`timescale 1ns / 1ps

module hrhp_len_acc
    import hrhp_pkg::*;
(
    input  logic [31:0] acc,
    input  logic [3:0]  digit,
    output logic [31:0] acc_new
);

    logic [35:0] wide;

    // Times ten as two shifted adds, plus the digit; clamp on overflow.
    assign wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, digit};
    assign acc_new = (wide[35:32] != 4'b0) ? 32'hFFFF_FFFF : wide[31:0];

endmodule

FILE: hdl/hrhp_parser.sv
`timescale 1ns / 1ps

module hrhp_parser
    import hrhp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output hrhp_result_t result
);

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  method_reg, method_next;
    logic [3:0]  mask_reg, mask_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;
    logic        closed_reg, closed_next;
    logic        cr_reg, cr_next;
    logic        empty_reg, empty_next;
    logic        skip_reg, skip_next;

    logic [3:0]  method_mask_adv;
    logic [3:0]  name_mask_adv;
    logic [2:0]  method_hit;
    logic [1:0]  name_hit;
    logic [3:0]  pos_inc;
    logic [31:0] acc_digit;
    logic        is_digit;
    logic [3:0]  cls;

    assign pos_inc  = (pos_reg < POS_MAX) ? pos_reg + 4'd1 : pos_reg;
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

    hrhp_len_acc u_len_acc (
        .acc     (acc_reg),
        .digit   (data_byte[3:0]),
        .acc_new (acc_digit)
    );

    // Candidate filters and first-match lookups for both word lists.
    always_comb
    begin
        method_mask_adv = mask_reg;
        name_mask_adv   = mask_reg;
        method_hit      = METH_UNKNOWN;
        name_hit        = HDR_NONE;
        for (int i = 0; i < NUM_METHODS; i++)
        begin
            if (mask_reg[i] && !(pos_reg < METHOD_LENS[i]
                                 && METHOD_CHARS[i][pos_reg] == data_byte))
            begin
                method_mask_adv[i] = 1'b0;
            end
        end
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            if (mask_reg[i] && !(pos_reg < NAME_LENS[i]
                                 && NAME_CHARS[i][pos_reg] == data_byte))
            begin
                name_mask_adv[i] = 1'b0;
            end
        end
        for (int i = NUM_METHODS - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && METHOD_LENS[i] == pos_reg)
            begin
                method_hit = 3'(i + 1);
            end
        end
        for (int i = NUM_NAMES - 1; i >= 0; i--)
        begin
            if (mask_reg[i] && NAME_LENS[i] == pos_reg)
            begin
                name_hit = 2'(i + 1);
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        method_next = method_reg;
        mask_next   = mask_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        closed_next = closed_reg;
        cr_next     = cr_reg;
        empty_next  = empty_reg;
        skip_next   = skip_reg;
        cls         = CLS_IGNORED;

        if (phase_reg == PH_IGNORE)
        begin
            cls = CLS_IGNORED;
        end
        else if (phase_reg == PH_BODY)
        begin
            cls = CLS_BODY;
        end
        else if (phase_reg == PH_METHOD)
        begin
            if (data_byte == CH_SP)
            begin
                method_next = method_hit;
                phase_next  = (method_hit != METH_UNKNOWN) ? PH_URI : PH_IGNORE;
                cls         = CLS_DELIM;
            end
            else
            begin
                mask_next = method_mask_adv;
                pos_next  = pos_inc;
                cls       = CLS_METHOD;
            end
        end
        else if (phase_reg == PH_URI)
        begin
            if (data_byte == CH_SP)
            begin
                phase_next = PH_VERSION;
                cls        = CLS_DELIM;
            end
            else
            begin
                cls = CLS_URI;
            end
        end
        else if (cr_reg && data_byte == CH_LF)
        begin
            cr_next = 1'b0;
            cls     = CLS_DELIM;
            if (phase_reg == PH_NAME && empty_reg)
            begin
                phase_next = PH_BODY;
            end
            else
            begin
                phase_next = PH_NAME;
                empty_next = 1'b1;
                mask_next  = 4'hF;
                pos_next   = 4'd0;
                skip_next  = 1'b0;
            end
        end
        else if (data_byte == CH_CR)
        begin
            cr_next   = 1'b1;
            skip_next = 1'b0;
            cls       = CLS_DELIM;
        end
        else
        begin
            cr_next    = 1'b0;
            empty_next = 1'b0;
            if (phase_reg == PH_VERSION)
            begin
                cls = CLS_VERSION;
            end
            else if (phase_reg == PH_NAME)
            begin
                if (data_byte == CH_COLON)
                begin
                    if (name_hit == HDR_CTYPE)
                    begin
                        phase_next = PH_CTYPE;
                    end
                    else if (name_hit != HDR_NONE)
                    begin
                        phase_next  = PH_LENGTH;
                        acc_next    = 32'd0;
                        seen_next   = 1'b1;
                        closed_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_OTHER;
                    end
                    skip_next = 1'b1;
                    cls       = CLS_DELIM;
                end
                else
                begin
                    mask_next = name_mask_adv;
                    pos_next  = pos_inc;
                    cls       = CLS_NAME;
                end
            end
            else if (skip_reg)
            begin
                // The single byte right after the colon.
                skip_next = 1'b0;
                cls       = CLS_DELIM;
            end
            else
            begin
                case (phase_reg)
                    PH_CTYPE:
                    begin
                        if (data_byte == CH_SEMI)
                        begin
                            phase_next = PH_CSEEK;
                            cls        = CLS_DELIM;
                        end
                        else
                        begin
                            cls = CLS_CTYPE;
                        end
                    end
                    PH_CSEEK:
                    begin
                        if (data_byte == CH_EQ)
                        begin
                            phase_next = PH_CHARSET;
                        end
                        cls = CLS_DELIM;
                    end
                    PH_CHARSET:
                    begin
                        cls = CLS_CHARSET;
                    end
                    PH_LENGTH:
                    begin
                        if (!closed_reg)
                        begin
                            if (is_digit)
                            begin
                                acc_next = acc_digit;
                            end
                            else
                            begin
                                closed_next = 1'b1;
                            end
                        end
                        cls = CLS_LENGTH;
                    end
                    default:
                    begin
                        cls = CLS_VALUE;
                    end
                endcase
            end
        end

        result.byte_class     = cls;
        result.method_code    = method_next;
        result.content_length = acc_next;
        result.length_present = seen_next;
        result.headers_done   = (phase_next == PH_BODY);

        // The final word of a message returns the parser to its start state.
        if (last_byte)
        begin
            phase_next  = PH_METHOD;
            method_next = METH_UNKNOWN;
            mask_next   = 4'hF;
            pos_next    = 4'd0;
            acc_next    = 32'd0;
            seen_next   = 1'b0;
            closed_next = 1'b0;
            cr_next     = 1'b0;
            empty_next  = 1'b1;
            skip_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            method_reg <= METH_UNKNOWN;
            mask_reg   <= 4'hF;
            pos_reg    <= 4'd0;
            acc_reg    <= 32'd0;
            seen_reg   <= 1'b0;
            closed_reg <= 1'b0;
            cr_reg     <= 1'b0;
            empty_reg  <= 1'b1;
            skip_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            method_reg <= method_next;
            mask_reg   <= mask_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            closed_reg <= closed_next;
            cr_reg     <= cr_next;
            empty_reg  <= empty_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

FILE: hdl/http_request_head_parser_top.sv
`timescale 1ns / 1ps

// HTTP request head parser. Each word carries one byte of a request message;
// each word in gives exactly one word out, holding the same byte tagged with
// its role (method, URI, version, delimiter, header name, content type,
// charset, Content-Length value, other header value, body or ignored), the decoded
// method, the running Content-Length value (saturating at 2^32-1), and flags
// for a seen Content-Length header and for the end of the header block. A
// word with last_byte set closes the message and the parser starts over at a
// request line. The block sustains one word per clock cycle in both
// directions while the output side is ready. An accepted word passes
// through the two registers on the path, the input register and then the
// result register, with the whole per-byte decision (name matching, phase
// update and the multiply-by-ten length accumulate) in one combinational
// stage between them.

module http_request_head_parser_top
    import hrhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [3:0]  byte_class,
    output logic [2:0]  method_code,
    output logic [31:0] content_length,
    output logic        length_present,
    output logic        headers_done,
    output logic        last_out
);

    // Input register stage.
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // Result register stage.
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;
    hrhp_result_t out_result_reg;

    hrhp_result_t result;
    logic         advance;

    // A held word moves into the result register whenever that register is
    // empty or is being emptied in this cycle. The parser state advances on
    // exactly those cycles, so stalls never skip or repeat a byte.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);

    // The input register can take a new word when it is empty or when its
    // current word moves on in the same cycle; this keeps one word per cycle
    // flowing while the output side is ready.
    assign in_ready = !in_valid_reg || advance;

    hrhp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_last_reg   <= in_last_reg;
            out_result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_class     = out_result_reg.byte_class;
    assign method_code    = out_result_reg.method_code;
    assign content_length = out_result_reg.content_length;
    assign length_present = out_result_reg.length_present;
    assign headers_done   = out_result_reg.headers_done;
    assign last_out       = out_last_reg;

endmodule

FILE: tb/tb_http_request_head_parser_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the HTTP request head parser.
//
// Every word sent in carries one request byte and an end-of-message flag. At the
// moment a word is accepted, a behavioral copy of the parser inside this bench
// tags the same byte and the expected output word goes onto a queue. Every word
// taken at the output is compared, field by field, with the oldest entry of
// that queue. The run opens with a short stimulus table walked by a loop. Then
// come random requests, most of them well formed (known method, URI, version,
// Content-Type and Content-Length headers, blank line and body) with random
// content, and the rest noise, unknown methods and messages cut short.
module tb_http_request_head_parser_top;
    import hrhp_pkg::*;

    // The package names only the unknown method code. A hit on method table
    // entry i is reported as code i + 1, so HEAD comes out as one.
    localparam logic [2:0] METH_HEAD = 3'd1;

    localparam int RANDOM_WORDS = 700;
    localparam int QUIET_FROM   = 250;
    localparam int QUIET_TO     = 400;
    localparam int IDLE_PCT     = 15;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIRECTED_ROWS = 21;

    // One output word as the parser should present it.
    typedef struct packed {
        logic [7:0]  data;
        logic [3:0]  cls;
        logic [2:0]  meth;
        logic [31:0] len;
        logic        len_seen;
        logic        hdr_done;
        logic        eom;
    } parse_word_t;

    // The part of a stimulus row that is written out by hand.
    typedef struct packed {
        logic [3:0]  cls;
        logic [2:0]  meth;
        logic [31:0] len;
        logic        len_seen;
        logic        hdr_done;
    } fixed_tag_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       fixed;
        fixed_tag_t want;
    } stim_row_t;

    // Rows whose expected word is worked out by the behavioral parser.
    localparam fixed_tag_t PREDICTED = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic [3:0]  byte_class;
    logic [2:0]  method_code;
    logic [31:0] content_length;
    logic        length_present;
    logic        headers_done;
    logic        last_out;

    http_request_head_parser_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_class     (byte_class),
        .method_code    (method_code),
        .content_length (content_length),
        .length_present (length_present),
        .headers_done   (headers_done),
        .last_out       (last_out)
    );

    // Expected output words, oldest first.
    parse_word_t pending_tags[$];
    int          mismatches;

    // While this is set neither side of the block idles.
    logic steady;

    // Bytes of the request being built for the random part.
    logic [7:0] req_q[$];

    // State of the behavioral parser.
    logic [3:0]  ps_phase;
    logic [2:0]  ps_method;
    logic [3:0]  ps_cands;
    logic [3:0]  ps_pos;
    logic [31:0] ps_len;
    logic        ps_len_seen;
    logic        ps_digits_done;
    logic        ps_cr_pending;
    logic        ps_line_blank;
    logic        ps_skip;

    // The table opens with an empty method, which makes the rest of that
    // message ignored. A HEAD request follows. Its version field holds a bare
    // LF and a CR that no LF follows. Then come a header line that is nothing
    // but a colon with the line end right after it, the blank line, and one
    // body byte that closes the message.
    stim_row_t dir_rows [DIRECTED_ROWS] = '{
        '{CH_SP, 1'b0, 1'b1, '{CLS_DELIM, METH_UNKNOWN, 32'd0, 1'b0, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{CLS_IGNORED, METH_UNKNOWN, 32'd0, 1'b0, 1'b0}},
        '{"H", 1'b0, 1'b0, PREDICTED},
        '{"E", 1'b0, 1'b0, PREDICTED},
        '{"A", 1'b0, 1'b0, PREDICTED},
        '{"D", 1'b0, 1'b0, PREDICTED},
        '{CH_SP, 1'b0, 1'b0, PREDICTED},
        '{8'h00, 1'b0, 1'b0, PREDICTED},
        '{CH_SP, 1'b0, 1'b0, PREDICTED},
        '{"H", 1'b0, 1'b0, PREDICTED},
        '{CH_LF, 1'b0, 1'b0, PREDICTED},
        '{CH_CR, 1'b0, 1'b0, PREDICTED},
        '{"X", 1'b0, 1'b0, PREDICTED},
        '{CH_CR, 1'b0, 1'b0, PREDICTED},
        '{CH_LF, 1'b0, 1'b0, PREDICTED},
        '{CH_COLON, 1'b0, 1'b0, PREDICTED},
        '{CH_CR, 1'b0, 1'b0, PREDICTED},
        '{CH_LF, 1'b0, 1'b0, PREDICTED},
        '{CH_CR, 1'b0, 1'b0, PREDICTED},
        '{CH_LF, 1'b0, 1'b0, PREDICTED},
        '{8'hFF, 1'b1, 1'b1, '{CLS_BODY, METH_HEAD, 32'd0, 1'b0, 1'b1}}
    };

    string method_names [4] = '{"HEAD", "GET", "POST", "OPTIONS"};
    string near_names [5] = '{"Content-Typ", "Content-Types", "content-type",
                              "Content-length", "Content-Lengthy"};

    // ------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------

    // Back to the start of a request line, as after reset.
    function automatic void restart_request();
        ps_phase       = PH_METHOD;
        ps_method      = METH_UNKNOWN;
        ps_cands       = 4'hF;
        ps_pos         = 4'd0;
        ps_len         = 32'd0;
        ps_len_seen    = 1'b0;
        ps_digits_done = 1'b0;
        ps_cr_pending  = 1'b0;
        ps_line_blank  = 1'b1;
        ps_skip        = 1'b0;
    endfunction

    // Drops every live candidate that does not hold this byte at the current
    // position, then moves the position on, holding it at its top value.
    function automatic void step_match(input logic methods, input logic [7:0] b);
        int         i;
        int         n;
        logic [7:0] c;
        logic [3:0] wlen;
        n = methods ? NUM_METHODS : NUM_NAMES;
        for (i = 0; i < n; i++) begin
            if (methods) begin
                c    = METHOD_CHARS[i][ps_pos];
                wlen = METHOD_LENS[i];
            end
            else begin
                c    = NAME_CHARS[i][ps_pos];
                wlen = NAME_LENS[i];
            end
            if (ps_cands[i] && !(ps_pos < wlen && c == b))
                ps_cands[i] = 1'b0;
        end
        if (ps_pos != POS_MAX)
            ps_pos = ps_pos + 4'd1;
    endfunction

    // The first live candidate whose full length has been matched, as its
    // index plus one, or zero when there is none.
    function automatic logic [2:0] best_match(input logic methods);
        int         i;
        int         n;
        logic [3:0] wlen;
        n = methods ? NUM_METHODS : NUM_NAMES;
        for (i = 0; i < n; i++) begin
            wlen = methods ? METHOD_LENS[i] : NAME_LENS[i % NUM_NAMES];
            if (ps_cands[i] && wlen == ps_pos)
                return 3'(i + 1);
        end
        return 3'd0;
    endfunction

    // Class of a byte inside a header value.
    function automatic logic [3:0] value_class(input logic [7:0] b);
        longint unsigned acc;
        if (ps_skip) begin
            ps_skip = 1'b0;
            return CLS_DELIM;
        end
        case (ps_phase)
            PH_CTYPE:
            begin
                if (b == CH_SEMI) begin
                    ps_phase = PH_CSEEK;
                    return CLS_DELIM;
                end
                return CLS_CTYPE;
            end
            PH_CSEEK:
            begin
                if (b == CH_EQ)
                    ps_phase = PH_CHARSET;
                return CLS_DELIM;
            end
            PH_CHARSET:
                return CLS_CHARSET;
            PH_LENGTH:
            begin
                if (!ps_digits_done) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        acc = longint'(ps_len) * 10 + longint'(b - CH_ZERO);
                        ps_len = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    end
                    else begin
                        ps_digits_done = 1'b1;
                    end
                end
                return CLS_LENGTH;
            end
            default:
                return CLS_VALUE;
        endcase
    endfunction

    // Tags one accepted byte and moves the parser state on.
    function automatic parse_word_t classify_byte(input logic [7:0] b, input logic eom);
        parse_word_t w;
        logic [3:0]  cls;
        logic [2:0]  hdr;
        if (ps_phase == PH_IGNORE) begin
            cls = CLS_IGNORED;
        end
        else if (ps_phase == PH_BODY) begin
            cls = CLS_BODY;
        end
        else if (ps_phase == PH_METHOD) begin
            if (b == CH_SP) begin
                ps_method = best_match(1'b1);
                ps_phase  = (ps_method != METH_UNKNOWN) ? PH_URI : PH_IGNORE;
                cls       = CLS_DELIM;
            end
            else begin
                step_match(1'b1, b);
                cls = CLS_METHOD;
            end
        end
        else if (ps_phase == PH_URI) begin
            if (b == CH_SP) begin
                ps_phase = PH_VERSION;
                cls      = CLS_DELIM;
            end
            else begin
                cls = CLS_URI;
            end
        end
        else if (ps_cr_pending && b == CH_LF) begin
            ps_cr_pending = 1'b0;
            cls           = CLS_DELIM;
            if (ps_phase == PH_NAME && ps_line_blank) begin
                ps_phase = PH_BODY;
            end
            else begin
                ps_phase      = PH_NAME;
                ps_line_blank = 1'b1;
                ps_cands      = 4'hF;
                ps_pos        = 4'd0;
                ps_skip       = 1'b0;
            end
        end
        else if (b == CH_CR) begin
            ps_cr_pending = 1'b1;
            ps_skip       = 1'b0;
            cls           = CLS_DELIM;
        end
        else begin
            ps_cr_pending = 1'b0;
            ps_line_blank = 1'b0;
            if (ps_phase == PH_VERSION) begin
                cls = CLS_VERSION;
            end
            else if (ps_phase == PH_NAME) begin
                if (b == CH_COLON) begin
                    hdr = best_match(1'b0);
                    if (hdr == HDR_CTYPE) begin
                        ps_phase = PH_CTYPE;
                    end
                    else if (hdr != HDR_NONE) begin
                        ps_phase       = PH_LENGTH;
                        ps_len         = 32'd0;
                        ps_len_seen    = 1'b1;
                        ps_digits_done = 1'b0;
                    end
                    else begin
                        ps_phase = PH_OTHER;
                    end
                    ps_skip = 1'b1;
                    cls     = CLS_DELIM;
                end
                else begin
                    step_match(1'b0, b);
                    cls = CLS_NAME;
                end
            end
            else begin
                cls = value_class(b);
            end
        end

        w.data     = b;
        w.cls      = cls;
        w.meth     = ps_method;
        w.len      = ps_len;
        w.len_seen = ps_len_seen;
        w.hdr_done = (ps_phase == PH_BODY);
        w.eom      = eom;
        if (eom)
            restart_request();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request builder for the random part
    // ------------------------------------------------------------------

    function automatic void push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            req_q.push_back(s[k]);
    endfunction

    function automatic void push_random(input int n, input int lo, input int hi);
        int k;
        for (k = 0; k < n; k++)
            req_q.push_back(8'($urandom_range(hi, lo)));
    endfunction

    function automatic void push_line_end();
        req_q.push_back(CH_CR);
        req_q.push_back(CH_LF);
    endfunction

    // Value of a Content-Length header: plain numbers mostly, now and then one
    // long enough to saturate, one with digits after a non-digit, one with a sign, or none.
    function automatic void push_length_value();
        if ($urandom_range(3) != 0)
            req_q.push_back(CH_SP);
        case ($urandom_range(9))
            0: push_random($urandom_range(14, 10), CH_ZERO, CH_NINE);
            1:
            begin
                push_random($urandom_range(3, 1), CH_ZERO, CH_NINE);
                push_text("x");
                push_random($urandom_range(3, 1), CH_ZERO, CH_NINE);
            end
            2:
            begin
                push_text($urandom_range(1) ? "+" : "-");
                push_random($urandom_range(4, 1), CH_ZERO, CH_NINE);
            end
            3: ;
            default: push_random($urandom_range(5, 1), CH_ZERO, CH_NINE);
        endcase
    endfunction

    // Value of a Content-Type header, with or without a charset part.
    function automatic void push_ctype_value();
        if ($urandom_range(3) != 0)
            req_q.push_back(CH_SP);
        push_random($urandom_range(6, 1), "a", "z");
        case ($urandom_range(4))
            0: ;
            1: push_text(";");
            2: push_text("; cs");
            default:
            begin
                push_text("; charset=");
                push_random($urandom_range(6, 1), "!", "~");
            end
        endcase
    endfunction

    // Value of any other header. Sometimes it holds a lone CR or a bare LF.
    function automatic void push_other_value();
        push_random($urandom_range(6), " ", "~");
        case ($urandom_range(5))
            0:
            begin
                req_q.push_back(CH_CR);
                push_random($urandom_range(3, 1), "!", "~");
            end
            1:
            begin
                req_q.push_back(CH_LF);
                push_random($urandom_range(3), "!", "~");
            end
            default: ;
        endcase
    endfunction

    function automatic void build_request();
        int    kind;
        int    n;
        int    k;
        string m;
        req_q.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            // Pure noise.
            push_random($urandom_range(12, 1), 0, 255);
        end
        else if (kind < 16) begin
            // Method that matches nothing: truncated, lengthened or random.
            m = method_names[$urandom_range(3)];
            case ($urandom_range(2))
                0: push_text(m.substr(0, m.len() - 2));
                1:
                begin
                    push_text(m);
                    push_random(1, "A", "Z");
                end
                default: push_random($urandom_range(8), "A", "Z");
            endcase
            req_q.push_back(CH_SP);
            push_random($urandom_range(6, 1), 0, 255);
        end
        else begin
            push_text(method_names[$urandom_range(3)]);
            req_q.push_back(CH_SP);
            push_text("/");
            push_random($urandom_range(6), "!", "~");
            req_q.push_back(CH_SP);
            if ($urandom_range(4) != 0)
                push_text("HTTP/1.1");
            else
                push_random($urandom_range(6), 0, 255);
            push_line_end();

            n = $urandom_range(4);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(11))
                    0, 1:
                    begin
                        push_text("Content-Type:");
                        push_ctype_value();
                    end
                    2, 3:
                    begin
                        push_text("Content-Length:");
                        push_length_value();
                    end
                    4:
                    begin
                        push_text("content-length:");
                        push_length_value();
                    end
                    5, 6:
                    begin
                        push_random($urandom_range(20, 1), "A", "z");
                        push_text(":");
                        push_other_value();
                    end
                    7:
                    begin
                        push_text(near_names[$urandom_range(4)]);
                        push_text(":");
                        push_other_value();
                    end
                    8:
                    begin
                        // Header line without a colon.
                        push_random($urandom_range(10, 1), "A", "z");
                    end
                    9:
                    begin
                        push_text(":");
                        push_other_value();
                    end
                    default:
                    begin
                        push_text("X-");
                        push_random($urandom_range(5, 1), "a", "z");
                        push_text(": ");
                        push_other_value();
                    end
                endcase
                push_line_end();
            end

            if ($urandom_range(9) != 0) begin
                push_line_end();
                push_random($urandom_range(6), 0, 255);
            end
            // Some messages end early, at any point.
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(req_q.size(), 1);
                while (req_q.size() > n)
                    void'(req_q.pop_back());
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, output side, checking
    // ------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The output side stalls at random with a chance of fifteen percent, except
    // inside the quiet stretch. Ready changes only at the falling edge.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    parse_word_t seen_tag;

    // Each word taken at the output is held against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_tags.size() == 0) begin
                $display("%0t: unexpected output word, byte %0h class %0d", $time,
                         out_byte, byte_class);
                mismatches++;
            end
            else begin
                seen_tag = pending_tags.pop_front();
                check_field("out_byte", seen_tag.data, out_byte);
                check_field("byte_class", seen_tag.cls, byte_class);
                check_field("method_code", seen_tag.meth, method_code);
                check_field("content_length", seen_tag.len, content_length);
                check_field("length_present", seen_tag.len_seen, length_present);
                check_field("headers_done", seen_tag.hdr_done, headers_done);
                check_field("last_out", seen_tag.eom, last_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one word from the next falling edge on, after a random number of
    // idle cycles, and returns at the rising edge where it is accepted. Valid
    // stays high with the same payload until then.
    task automatic send_word(input logic [7:0] b, input logic eom);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial begin
        int          i;
        int          counted;
        parse_word_t w;

        mismatches = 0;
        steady     = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        last_byte  = 1'b0;
        rst_n      = 1'b0;
        restart_request();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Stimulus table. Rows with a hand-written tag still go through the
        // behavioral parser so that its state follows the block.
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(dir_rows[i].data, dir_rows[i].eom);
            w = classify_byte(dir_rows[i].data, dir_rows[i].eom);
            if (dir_rows[i].fixed) begin
                w.cls      = dir_rows[i].want.cls;
                w.meth     = dir_rows[i].want.meth;
                w.len      = dir_rows[i].want.len;
                w.len_seen = dir_rows[i].want.len_seen;
                w.hdr_done = dir_rows[i].want.hdr_done;
            end
            pending_tags.push_back(w);
        end

        // Random requests. Bytes that the parser ignores after an unknown
        // method do not count toward the length of this part.
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            build_request();
            for (i = 0; i < req_q.size(); i++) begin
                steady = (counted >= QUIET_FROM) && (counted < QUIET_TO);
                send_word(req_q[i], i == req_q.size() - 1);
                w = classify_byte(req_q[i], i == req_q.size() - 1);
                pending_tags.push_back(w);
                if (w.cls != CLS_IGNORED)
                    counted++;
            end
        end
        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then allow a few more cycles for anything unexpected.
        while (pending_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
